[rtl/core/hwm_pkg.sv]
package hwm_pkg;

  localparam int MAX_FRAME   = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int PORT_BITS   = 32;
  // bits of s_tdata taken as the sample, sign extended to SAMPLE_BITS
  localparam int IN_BITS     = (SAMPLE_BITS < PORT_BITS) ? SAMPLE_BITS : PORT_BITS;
  // largest exponent whose frame fits in MAX_FRAME
  localparam int LOG_MAX     = $clog2(MAX_FRAME + 1) - 1;
  localparam int ADDR_W      = LOG_MAX;
  localparam int LEN_W       = LOG_MAX + 1;
  localparam int LOG_W       = 3;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 3;
  localparam int LOG2_LEN_RESET = 6;

  localparam int SCALE_Q16   = 46341;  // 1/sqrt2 in Q0.16
  localparam int FRAC_BITS   = 16;
  localparam int SUM_W       = SAMPLE_BITS + 1;
  localparam int PROD_W      = SUM_W + FRAC_BITS + 1;

  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [SAMPLE_BITS-1:0] word_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOG2_LEN,
    REG_INVERSE
  } cfg_reg_t;

  // one classified input beat
  typedef struct packed {
    word_t             sample;
    logic [ADDR_W-1:0] idx;
    logic              last;
    logic [LOG_W-1:0]  log2_len;  // already clamped to 1..LOG_MAX
    logic              inverse;
  } q_entry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_XFORM,
    ST_DRAIN,
    ST_EMIT
  } bk_state_t;

endpackage

[rtl/core/hwm_front.sv]
module hwm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [hwm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [hwm_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [hwm_pkg::PORT_BITS-1:0]     s_tdata,
  output logic                              push,
  output hwm_pkg::q_entry_t                 push_entry,
  input  logic                              q_full
);

  logic [hwm_pkg::LOG_W-1:0]  log2_len;
  logic                       inverse;
  logic [hwm_pkg::ADDR_W-1:0] fill;
  logic [hwm_pkg::LOG_W-1:0]  k_eff;
  logic [hwm_pkg::LEN_W-1:0]  len_m1;
  logic                       is_last;

  function automatic logic [hwm_pkg::LOG_W-1:0] clamp_log2(
    input logic [hwm_pkg::LOG_W-1:0] k
  );
    logic [hwm_pkg::LOG_W-1:0] r;
    if (k == '0) begin
      r = hwm_pkg::LOG_W'(1);
    end else if (k > hwm_pkg::LOG_W'(hwm_pkg::LOG_MAX)) begin
      r = hwm_pkg::LOG_W'(hwm_pkg::LOG_MAX);
    end else begin
      r = k;
    end
    return r;
  endfunction

  assign k_eff   = clamp_log2(log2_len);
  assign len_m1  = (hwm_pkg::LEN_W'(1) << k_eff) - hwm_pkg::LEN_W'(1);
  assign is_last = (fill == len_m1[hwm_pkg::ADDR_W-1:0]);

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  assign push_entry.sample   =
    hwm_pkg::SAMPLE_BITS'(signed'(s_tdata[hwm_pkg::IN_BITS-1:0]));
  assign push_entry.idx      = fill;
  assign push_entry.last     = is_last;
  assign push_entry.log2_len = k_eff;
  assign push_entry.inverse  = inverse;

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_len <= hwm_pkg::LOG_W'(hwm_pkg::LOG2_LEN_RESET);
      inverse  <= 1'b0;
      fill     <= '0;
    end else if (cfg_wr_en) begin
      // any register write drops a partial frame
      if (cfg_addr == hwm_pkg::REG_LOG2_LEN) begin
        log2_len <= cfg_wr_data;
      end else begin
        inverse <= cfg_wr_data[0];
      end
      fill <= '0;
    end else if (push) begin
      fill <= is_last ? '0 : fill + hwm_pkg::ADDR_W'(1);
    end
  end

endmodule

[rtl/core/hwm_queue.sv]
module hwm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hwm_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output hwm_pkg::q_entry_t q_entry
);

  localparam int PTR_W = $clog2(hwm_pkg::QUEUE_DEPTH);

  hwm_pkg::q_entry_t entries [hwm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign full    = (count == (PTR_W+1)'(hwm_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

[rtl/core/hwm_back.sv]
module hwm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  hwm_pkg::q_entry_t             q_entry,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [hwm_pkg::PORT_BITS-1:0] m_tdata,
  output logic                          m_tlast,
  output logic                          m_tuser
);

  localparam int AW = hwm_pkg::ADDR_W;
  localparam int LW = hwm_pkg::LOG_W;
  localparam int SB = hwm_pkg::SAMPLE_BITS;
  localparam int YW = hwm_pkg::PROD_W - hwm_pkg::FRAC_BITS;
  localparam logic signed [hwm_pkg::FRAC_BITS:0] SCALE_C =
    (hwm_pkg::FRAC_BITS + 1)'(hwm_pkg::SCALE_Q16);
  localparam logic signed [hwm_pkg::PROD_W-1:0] ROUND_C =
    hwm_pkg::PROD_W'(1 << (hwm_pkg::FRAC_BITS - 1));
  localparam logic signed [YW-1:0] SAT_HI = {{(YW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [YW-1:0] SAT_LO = {{(YW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  hwm_pkg::bk_state_t state, state_next;

  logic [LW-1:0] frame_log2;
  logic          inverse;
  logic [LW-1:0] level;
  logic [AW-1:0] bfly;
  logic [AW-1:0] e_idx;
  logic          primed;
  logic          clip;

  // two banks; levels ping-pong between them, intake writes both
  logic [SB-1:0] mem0 [hwm_pkg::MAX_FRAME];
  logic [SB-1:0] mem1 [hwm_pkg::MAX_FRAME];
  logic [SB-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
  logic          rd_sel_q;

  logic          rd_bank;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic          wr_en0, wr_en1;
  logic [AW-1:0] wr_addr;
  logic [SB-1:0] wr_data;

  logic                    p1_valid, p1_op, p1_bank;
  logic [AW-1:0]           p1_dst;
  logic                    p2_valid, p2_bank;
  logic [AW-1:0]           p2_dst;
  logic signed [hwm_pkg::SUM_W-1:0] p2_sum;
  logic                    p3_valid, p3_bank;
  logic [AW-1:0]           p3_dst;
  logic signed [hwm_pkg::PROD_W-1:0] p3_prod;

  logic signed [hwm_pkg::PROD_W-1:0] rnd;
  logic signed [YW-1:0]    y;
  logic                    over, under;
  logic [SB-1:0]           sat_val;

  logic [LW-1:0]   klast;
  logic [LW-1:0]   shamt;
  logic [AW-1:0]   half;
  logic [AW:0]     lvl_m1;
  logic [AW-1:0]   pair;
  logic            bfly_last;
  logic            pipe_busy;
  logic [hwm_pkg::LEN_W-1:0] frame_m1_w;
  logic [AW-1:0]   frame_m1;
  logic            fire;
  logic [AW-1:0]   e_fetch;
  logic [LW-1:0]   e_level;
  logic            emit_bank;
  logic signed [SB-1:0] a_data, b_data;

  function automatic logic [hwm_pkg::LOG_W-1:0] msb_pos(
    input logic [hwm_pkg::ADDR_W-1:0] v
  );
    logic [hwm_pkg::LOG_W-1:0] p;
    p = '0;
    for (int b = 1; b < hwm_pkg::ADDR_W; b++) begin
      if (v[b]) begin
        p = hwm_pkg::LOG_W'(b);
      end
    end
    return p;
  endfunction

  // level geometry
  assign klast     = frame_log2 - LW'(1);
  assign shamt     = inverse ? level : (klast - level);
  assign half      = AW'(1) << shamt;
  assign lvl_m1    = {half - AW'(1), 1'b1};
  assign pair      = bfly >> 1;
  assign bfly_last = (bfly == lvl_m1[AW-1:0]);
  assign pipe_busy = p1_valid || p2_valid || p3_valid;

  assign frame_m1_w = (hwm_pkg::LEN_W'(1) << frame_log2) - hwm_pkg::LEN_W'(1);
  assign frame_m1   = frame_m1_w[AW-1:0];

  // emit: forward coefficients sit in the bank of the level that finished them
  assign fire      = (state == hwm_pkg::ST_EMIT) && primed && (!m_tvalid || m_tready);
  assign e_fetch   = e_idx + AW'(fire);
  assign e_level   = klast - msb_pos(e_fetch);
  assign emit_bank = inverse ? ~klast[0] : ~e_level[0];

  assign a_data = rd_sel_q ? rd1_a : rd0_a;
  assign b_data = rd_sel_q ? rd1_b : rd0_b;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hwm_pkg::ST_LOAD: begin
        if (q_valid && q_entry.last) begin
          state_next = hwm_pkg::ST_XFORM;
        end
      end
      hwm_pkg::ST_XFORM: begin
        if (bfly_last) begin
          state_next = hwm_pkg::ST_DRAIN;
        end
      end
      hwm_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = (level == klast) ? hwm_pkg::ST_EMIT : hwm_pkg::ST_XFORM;
        end
      end
      hwm_pkg::ST_EMIT: begin
        if (fire && e_idx == frame_m1) begin
          state_next = hwm_pkg::ST_LOAD;
        end
      end
      default: state_next = hwm_pkg::ST_LOAD;
    endcase
  end

  // outputs of the sequencer: memory addresses and write port
  always_comb begin
    pop       = (state == hwm_pkg::ST_LOAD) && q_valid;
    rd_bank   = level[0];
    rd_addr_a = inverse ? pair : (pair << 1);
    rd_addr_b = inverse ? (half + pair) : ((pair << 1) | AW'(1));
    if (state == hwm_pkg::ST_EMIT) begin
      rd_bank   = emit_bank;
      rd_addr_a = e_fetch;
    end
    if (pop) begin
      wr_en0  = 1'b1;
      wr_en1  = 1'b1;
      wr_addr = q_entry.idx;
      wr_data = q_entry.sample;
    end else begin
      wr_en0  = p3_valid && !p3_bank;
      wr_en1  = p3_valid && p3_bank;
      wr_addr = p3_dst;
      wr_data = sat_val;
    end
  end

  // round to nearest (ties up) and clip
  assign rnd     = p3_prod + ROUND_C;
  assign y       = rnd[hwm_pkg::PROD_W-1:hwm_pkg::FRAC_BITS];
  assign over    = (y > SAT_HI);
  assign under   = (y < SAT_LO);
  assign sat_val = over ? SAT_HI[SB-1:0] : (under ? SAT_LO[SB-1:0] : y[SB-1:0]);

  always_ff @(posedge clk) begin
    if (wr_en0) begin
      mem0[wr_addr] <= wr_data;
    end
    rd0_a <= mem0[rd_addr_a];
    rd0_b <= mem0[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (wr_en1) begin
      mem1[wr_addr] <= wr_data;
    end
    rd1_a <= mem1[rd_addr_a];
    rd1_b <= mem1[rd_addr_b];
  end

  // butterfly datapath payload
  always_ff @(posedge clk) begin
    rd_sel_q <= rd_bank;
    p1_op    <= bfly[0];
    p1_bank  <= ~level[0];
    p1_dst   <= inverse ? ((pair << 1) | AW'(bfly[0])) : (bfly[0] ? half + pair : pair);
    p2_bank  <= p1_bank;
    p2_dst   <= p1_dst;
    p2_sum   <= p1_op ? (hwm_pkg::SUM_W'(a_data) - hwm_pkg::SUM_W'(b_data))
                      : (hwm_pkg::SUM_W'(a_data) + hwm_pkg::SUM_W'(b_data));
    p3_bank  <= p2_bank;
    p3_dst   <= p2_dst;
    p3_prod  <= p2_sum * SCALE_C;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hwm_pkg::ST_LOAD;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      frame_log2 <= LW'(hwm_pkg::LOG2_LEN_RESET);
      inverse  <= 1'b0;
      level    <= '0;
      bfly     <= '0;
      e_idx    <= '0;
      primed   <= 1'b0;
      clip     <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= (state == hwm_pkg::ST_XFORM);
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      primed   <= (state == hwm_pkg::ST_EMIT) && (state_next == hwm_pkg::ST_EMIT);
      if (p3_valid && (over || under)) begin
        clip <= 1'b1;
      end
      case (state)
        hwm_pkg::ST_LOAD: begin
          if (q_valid && q_entry.last) begin
            frame_log2 <= q_entry.log2_len;
            inverse    <= q_entry.inverse;
            level      <= '0;
            bfly       <= '0;
            clip       <= 1'b0;
          end
        end
        hwm_pkg::ST_XFORM: begin
          bfly <= bfly_last ? '0 : bfly + AW'(1);
        end
        hwm_pkg::ST_DRAIN: begin
          if (!pipe_busy) begin
            if (level == klast) begin
              e_idx <= '0;
            end else begin
              level <= level + LW'(1);
            end
          end
        end
        hwm_pkg::ST_EMIT: begin
          if (fire) begin
            e_idx <= e_idx + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= hwm_pkg::PORT_BITS'(a_data);
      m_tlast <= (e_idx == frame_m1);
      m_tuser <= clip;
    end
  end

  a_no_wb_in_load: assert property (@(posedge clk) disable iff (rst)
    (state == hwm_pkg::ST_LOAD) |-> !p3_valid)
    else $error("butterfly write-back during intake");

  a_emit_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == hwm_pkg::ST_EMIT) |-> (e_idx <= frame_m1))
    else $error("emit index past frame end");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (state == hwm_pkg::ST_XFORM) |-> (level <= klast))
    else $error("transform level out of range");

  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    (fire && e_idx == frame_m1) |=> (m_tvalid && m_tlast && state == hwm_pkg::ST_LOAD))
    else $error("frame end not marked on last beat");

endmodule

[rtl/core/haar_wavelet_multilevel.sv]
// Multilevel orthonormal Haar transform over frames of 2^log2_frame_length
// signed Q15.16 samples (forward: averages first, inverse: reconstruction).
// Samples enter one beat per cycle into a 4-beat queue while it is not full;
// once the last sample of a frame is in, the transform runs on one shared
// butterfly unit (one multiply by 46341/2^16, round to nearest, saturate) at
// one butterfly per cycle, 2N-2 butterflies in all, with a pipeline drain
// after each level; the frame then streams out at one beat per cycle while
// m_tready is high, tlast on the last element and tuser set on every beat of
// a frame in which any butterfly clipped. Intake of the next frame is held
// off (after the queue fills) while the single butterfly unit and its
// two-bank frame memory are busy. Writing either configuration register drops
// a partly received frame; write registers only while the block is idle.
module haar_wavelet_multilevel (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [hwm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hwm_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [hwm_pkg::PORT_BITS-1:0]  s_tdata,   // [31:0] sample_in
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [hwm_pkg::PORT_BITS-1:0]  m_tdata,   // [31:0] value_out
  output logic                           m_tlast,   // frame_end
  output logic                           m_tuser    // [0] saturated
);

  logic              push;
  hwm_pkg::q_entry_t push_entry;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  hwm_pkg::q_entry_t q_entry;

  hwm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full)
  );

  hwm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  hwm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
